// File: hdl/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// shared types and constants of the convex hull area block
// ----------------------------------------------------------------------------
package cha_pkg;

    localparam int AREA_BITS = 33;
    localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

    // one point request
    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               last_point;
    } req_t;

    // one hull result
    typedef struct packed {
        logic [AREA_BITS-1:0] doubled_area;
        logic                 overflowed;
    } res_t;

endpackage

// File: hdl/cha_ram.sv
// ----------------------------------------------------------------------------
// cha_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/cha_cross.sv
// ----------------------------------------------------------------------------
// cha_cross
// pipelined cross product (b - a) x (c - a): registered differences, products, then result
// ----------------------------------------------------------------------------
module cha_cross #(
    parameter int CB = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [CB-1:0]   ax,
    input  logic signed [CB-1:0]   ay,
    input  logic signed [CB-1:0]   bx,
    input  logic signed [CB-1:0]   by,
    input  logic signed [CB-1:0]   cx,
    input  logic signed [CB-1:0]   cy,
    output logic                   done,
    output logic signed [2*CB+2:0] prod
);

    logic [2:0] vld_reg;
    logic signed [CB:0] dbx_reg, dby_reg, dcx_reg, dcy_reg;
    logic signed [2*CB+1:0] p0_reg, p1_reg;
    logic signed [2*CB+2:0] res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        // differences
        dbx_reg <= (CB+1)'(bx) - (CB+1)'(ax);
        dby_reg <= (CB+1)'(by) - (CB+1)'(ay);
        dcx_reg <= (CB+1)'(cx) - (CB+1)'(ax);
        dcy_reg <= (CB+1)'(cy) - (CB+1)'(ay);
        // products
        p0_reg  <= dbx_reg * dcy_reg;
        p1_reg  <= dby_reg * dcx_reg;
        res_reg <= (2*CB+3)'(p0_reg) - (2*CB+3)'(p1_reg);
    end

    assign done = vld_reg[2];
    assign prod = res_reg;

endmodule

// File: hdl/convex_hull_area.sv
// ----------------------------------------------------------------------------
// convex_hull_area
// doubled area of the convex hull of a point set (graham scan)
// ----------------------------------------------------------------------------
// throughput: one point request per cycle while loading (busy low)
// sequence: after the last point, order fill, then an insertion sort with its
//   compares per sort position, stack seeding, per scan point a fetch and its
//   turn tests, one cross product per area term, an output step, done the next
//   cycle; paced by the single read port of each ram and the pipelined cross unit
// the result strobe (done) lasts one cycle; the receiver cannot stall it
// reset: asynchronous, clears control state; the rams are not cleared
// ----------------------------------------------------------------------------
module convex_hull_area #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cha_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output cha_pkg::res_t result
);

    localparam int CB   = COORD_BITS;
    localparam int IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int XW   = 2 * CB + 3;
    localparam int ACCW = XW + CNTW;
    localparam int SUMW = (ACCW > cha_pkg::AREA_BITS + 1) ? ACCW : cha_pkg::AREA_BITS + 1;

    // sequencer codes
    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_FILL  = 5'd1;
    localparam logic [4:0] ST_SI_RD = 5'd2;
    localparam logic [4:0] ST_SI_PT = 5'd3;
    localparam logic [4:0] ST_SI_PV = 5'd4;
    localparam logic [4:0] ST_SJ_RD = 5'd5;
    localparam logic [4:0] ST_SJ_PT = 5'd6;
    localparam logic [4:0] ST_SJ_X  = 5'd7;
    localparam logic [4:0] ST_SJ_W  = 5'd8;
    localparam logic [4:0] ST_SI_WR = 5'd9;
    localparam logic [4:0] ST_H0    = 5'd10;
    localparam logic [4:0] ST_H1    = 5'd11;
    localparam logic [4:0] ST_H2    = 5'd12;
    localparam logic [4:0] ST_SQ_RD = 5'd13;
    localparam logic [4:0] ST_SQ_PT = 5'd14;
    localparam logic [4:0] ST_SQ_PV = 5'd15;
    localparam logic [4:0] ST_SL    = 5'd16;
    localparam logic [4:0] ST_SL_T  = 5'd17;
    localparam logic [4:0] ST_SL_A  = 5'd18;
    localparam logic [4:0] ST_SL_X  = 5'd19;
    localparam logic [4:0] ST_SL_W  = 5'd20;
    localparam logic [4:0] ST_PUSH  = 5'd21;
    localparam logic [4:0] ST_AR_0  = 5'd22;
    localparam logic [4:0] ST_AR_RD = 5'd23;
    localparam logic [4:0] ST_AR_B  = 5'd24;
    localparam logic [4:0] ST_AR_C  = 5'd25;
    localparam logic [4:0] ST_AR_X  = 5'd26;
    localparam logic [4:0] ST_AR_W  = 5'd27;
    localparam logic [4:0] ST_OUT   = 5'd28;

    // control state
    logic [4:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            drop_reg, drop_next;
    logic [CNTW-1:0] n_reg, n_next;
    logic [CNTW-1:0] i_reg, i_next;
    logic [CNTW-1:0] j_reg, j_next;
    logic [CNTW-1:0] k_reg, k_next;
    logic            out_vld_reg;

    // payload state
    logic [IDXW-1:0]        piv_reg, piv_next;
    logic signed [CB-1:0]   pivx_reg, pivx_next, pivy_reg, pivy_next;
    logic [IDXW-1:0]        v_reg, v_next, u_reg, u_next, q_reg, q_next;
    logic signed [CB-1:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic signed [CB-1:0]   ux_reg, ux_next, uy_reg, uy_next;
    logic signed [CB-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic signed [CB-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    cha_pkg::res_t          res_reg, res_next;

    // ram ports
    logic                pt_we, ord_we, stk_we;
    logic [IDXW-1:0]     pt_waddr, pt_raddr, ord_waddr, ord_raddr, stk_waddr, stk_raddr;
    logic [2*CB-1:0]     pt_wdata, pt_rdata;
    logic [IDXW-1:0]     ord_wdata, ord_rdata, stk_wdata, stk_rdata;
    logic signed [CB-1:0] rd_x, rd_y;

    // cross product unit
    logic                 x_start, x_done;
    logic signed [CB-1:0] x_ax, x_ay, x_bx, x_by, x_cx, x_cy;
    logic signed [XW-1:0] x_prod;

    // incoming point, low COORD_BITS taken as two's complement
    logic signed [CB-1:0] in_x, in_y;
    logic                 accept, store_ok, prec;
    logic signed [CB:0]   sum_v, sum_u;
    logic [ACCW-1:0]      acc_abs;
    logic [SUMW-1:0]      acc_wide;

    assign in_x     = CB'($unsigned(request.x_coord));
    assign in_y     = CB'($unsigned(request.y_coord));
    assign busy     = (state_reg != ST_LOAD);
    assign accept   = start && !busy;
    assign store_ok = (cnt_reg < CNTW'(MAX_POINTS));
    assign rd_x     = pt_rdata[2*CB-1:CB];
    assign rd_y     = pt_rdata[CB-1:0];

    // v strictly before u about the pivot; collinear ties by smaller x+y
    assign sum_v = (CB+1)'(vx_reg) + (CB+1)'(vy_reg);
    assign sum_u = (CB+1)'(ux_reg) + (CB+1)'(uy_reg);
    assign prec  = (x_prod == '0) ? (sum_v < sum_u) : (x_prod > 0);

    assign acc_abs  = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);
    assign acc_wide = SUMW'(acc_abs);

    cha_ram #(.DEPTH(MAX_POINTS), .WIDTH(2*CB)) u_pt_ram (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    cha_ram #(.DEPTH(MAX_POINTS), .WIDTH(IDXW)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    cha_ram #(.DEPTH(MAX_POINTS), .WIDTH(IDXW)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    cha_cross #(.CB(CB)) u_cross (
        .clk(clk), .rst_n(rst_n), .start(x_start),
        .ax(x_ax), .ay(x_ay), .bx(x_bx), .by(x_by), .cx(x_cx), .cy(x_cy),
        .done(x_done), .prod(x_prod)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        piv_next   = piv_reg;
        pivx_next  = pivx_reg;
        pivy_next  = pivy_reg;
        v_next     = v_reg;
        u_next     = u_reg;
        q_next     = q_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;

        pt_we     = 1'b0;
        pt_waddr  = cnt_reg[IDXW-1:0];
        pt_wdata  = {in_x, in_y};
        pt_raddr  = '0;
        ord_we    = 1'b0;
        ord_waddr = k_reg[IDXW-1:0];
        ord_wdata = i_reg[IDXW-1:0];
        ord_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = k_reg[IDXW-1:0];
        stk_wdata = q_reg;
        stk_raddr = '0;

        x_start = 1'b0;
        x_ax = pivx_reg;
        x_ay = pivy_reg;
        x_bx = vx_reg;
        x_by = vy_reg;
        x_cx = rd_x;
        x_cy = rd_y;

        case (state_reg)
            // take points, track the lowest-then-leftmost one as pivot
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        pt_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0 || in_y < pivy_reg ||
                            (in_y == pivy_reg && in_x < pivx_reg))
                        begin
                            piv_next  = cnt_reg[IDXW-1:0];
                            pivx_next = in_x;
                            pivy_next = in_y;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (request.last_point)
                    begin
                        n_next = store_ok ? cnt_reg + 1'b1 : cnt_reg;
                        i_next = '0;
                        k_next = '0;
                        acc_next = '0;
                        if (n_next < CNTW'(3))
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_FILL;
                        end
                    end
                end
            end
            // order list of all points except the pivot
            ST_FILL:
            begin
                if (i_reg[IDXW-1:0] != piv_reg)
                begin
                    ord_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == n_reg - 1'b1)
                begin
                    i_next     = CNTW'(1);
                    state_next = ST_SI_RD;
                end
            end
            // insertion sort: fetch v = order[i]
            ST_SI_RD:
            begin
                ord_raddr  = i_reg[IDXW-1:0];
                j_next     = i_reg;
                state_next = ST_SI_PT;
            end
            ST_SI_PT:
            begin
                v_next     = ord_rdata;
                pt_raddr   = ord_rdata;
                state_next = ST_SI_PV;
            end
            ST_SI_PV:
            begin
                vx_next    = rd_x;
                vy_next    = rd_y;
                state_next = ST_SJ_RD;
            end
            // compare v against u = order[j-1]
            ST_SJ_RD:
            begin
                ord_raddr  = IDXW'(j_reg - 1'b1);
                state_next = ST_SJ_PT;
            end
            ST_SJ_PT:
            begin
                u_next     = ord_rdata;
                pt_raddr   = ord_rdata;
                state_next = ST_SJ_X;
            end
            ST_SJ_X:
            begin
                ux_next    = rd_x;
                uy_next    = rd_y;
                x_start    = 1'b1;
                state_next = ST_SJ_W;
            end
            ST_SJ_W:
            begin
                if (x_done)
                begin
                    if (prec)
                    begin
                        ord_we    = 1'b1;
                        ord_waddr = j_reg[IDXW-1:0];
                        ord_wdata = u_reg;
                        j_next    = j_reg - 1'b1;
                        state_next = (j_reg == CNTW'(1)) ? ST_SI_WR : ST_SJ_RD;
                    end
                    else
                    begin
                        state_next = ST_SI_WR;
                    end
                end
            end
            ST_SI_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = j_reg[IDXW-1:0];
                ord_wdata = v_reg;
                i_next    = i_reg + 1'b1;
                if ((CNTW+1)'(i_reg) + 2'd2 < (CNTW+1)'(n_reg))
                begin
                    state_next = ST_SI_RD;
                end
                else
                begin
                    state_next = ST_H0;
                end
            end
            // stack seeded with pivot, order[0], order[1]
            ST_H0:
            begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = piv_reg;
                ord_raddr  = '0;
                state_next = ST_H1;
            end
            ST_H1:
            begin
                stk_we     = 1'b1;
                stk_waddr  = IDXW'(1);
                stk_wdata  = ord_rdata;
                ord_raddr  = IDXW'(1);
                state_next = ST_H2;
            end
            ST_H2:
            begin
                stk_we    = 1'b1;
                stk_waddr = IDXW'(2 % MAX_POINTS);
                stk_wdata = ord_rdata;
                k_next    = CNTW'(3);
                i_next    = CNTW'(2);
                state_next = (n_reg == CNTW'(3)) ? ST_AR_0 : ST_SQ_RD;
            end
            // scan: fetch q = order[i]
            ST_SQ_RD:
            begin
                ord_raddr  = i_reg[IDXW-1:0];
                state_next = ST_SQ_PT;
            end
            ST_SQ_PT:
            begin
                q_next     = ord_rdata;
                pt_raddr   = ord_rdata;
                state_next = ST_SQ_PV;
            end
            ST_SQ_PV:
            begin
                qx_next    = rd_x;
                qy_next    = rd_y;
                state_next = ST_SL;
            end
            // pop while the turn is not strictly left
            ST_SL:
            begin
                if (k_reg > CNTW'(1))
                begin
                    stk_raddr  = IDXW'(k_reg - 1'b1);
                    state_next = ST_SL_T;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_SL_T:
            begin
                pt_raddr   = stk_rdata;
                stk_raddr  = IDXW'(k_reg - 2'd2);
                state_next = ST_SL_A;
            end
            ST_SL_A:
            begin
                tx_next    = rd_x;
                ty_next    = rd_y;
                pt_raddr   = stk_rdata;
                state_next = ST_SL_X;
            end
            ST_SL_X:
            begin
                x_start    = 1'b1;
                x_ax       = rd_x;
                x_ay       = rd_y;
                x_bx       = tx_reg;
                x_by       = ty_reg;
                x_cx       = qx_reg;
                x_cy       = qy_reg;
                state_next = ST_SL_W;
            end
            ST_SL_W:
            begin
                if (x_done)
                begin
                    if (x_prod > 0)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = ST_SL;
                    end
                end
            end
            ST_PUSH:
            begin
                stk_we = 1'b1;
                k_next = k_reg + 1'b1;
                i_next = i_reg + 1'b1;
                if ((CNTW+1)'(i_reg) + 2'd2 < (CNTW+1)'(n_reg))
                begin
                    state_next = ST_SQ_RD;
                end
                else
                begin
                    state_next = ST_AR_0;
                end
            end
            // shoelace fan about the pivot
            ST_AR_0:
            begin
                acc_next   = '0;
                i_next     = CNTW'(1);
                state_next = (k_reg < CNTW'(3)) ? ST_OUT : ST_AR_RD;
            end
            ST_AR_RD:
            begin
                stk_raddr  = i_reg[IDXW-1:0];
                state_next = ST_AR_B;
            end
            ST_AR_B:
            begin
                pt_raddr   = stk_rdata;
                stk_raddr  = IDXW'(i_reg + 1'b1);
                state_next = ST_AR_C;
            end
            ST_AR_C:
            begin
                vx_next    = rd_x;
                vy_next    = rd_y;
                pt_raddr   = stk_rdata;
                state_next = ST_AR_X;
            end
            ST_AR_X:
            begin
                x_start    = 1'b1;
                state_next = ST_AR_W;
            end
            ST_AR_W:
            begin
                if (x_done)
                begin
                    acc_next = acc_reg + ACCW'(x_prod);
                    i_next   = i_reg + 1'b1;
                    if ((CNTW+1)'(i_reg) + 2'd2 < (CNTW+1)'(k_reg))
                    begin
                        state_next = ST_AR_RD;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                res_next.doubled_area = (acc_wide > SUMW'(cha_pkg::AREA_MAX)) ?
                                        cha_pkg::AREA_MAX :
                                        acc_wide[cha_pkg::AREA_BITS-1:0];
                res_next.overflowed   = drop_reg;
                cnt_next   = '0;
                drop_next  = 1'b0;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            out_vld_reg <= (state_reg == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        piv_reg  <= piv_next;
        pivx_reg <= pivx_next;
        pivy_reg <= pivy_next;
        v_reg    <= v_next;
        u_reg    <= u_next;
        q_reg    <= q_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign done   = out_vld_reg;
    assign result = res_reg;

    // result strobe only follows the output step
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_OUT))
        else $error("result strobe without output step");

    // the last point of a set closes the load window
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.last_point) |=> busy)
        else $error("last point did not start the hull pass");

    // store fill count never passes capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_POINTS))
        else $error("point count past capacity");

    // hull stack never deeper than the set
    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD && state_reg != ST_FILL) |-> k_reg <= n_reg)
        else $error("hull stack deeper than point set");

endmodule

// File: tb/sv/tb_convex_hull_area.sv
// ----------------------------------------------------------------------------
// tb_convex_hull_area
// self-checking bench for the convex hull area block
// ----------------------------------------------------------------------------
// point sets are queued by an initial block and fed by a clocked driver. On
// every accepted request a local graham scan model updates its own point
// store and, on the last point of a set, queues the expected doubled area.
// A clocked monitor compares each done strobe with the oldest expectation.
// Sender gaps vary by phase, and one set waits for the block to drain first.
// ----------------------------------------------------------------------------
module tb_convex_hull_area;

    localparam int MAX_PTS = 1024;
    localparam int TARGET_POINTS = 1250;

    // one queued request plus how the driver should present it
    typedef struct {
        cha_pkg::req_t req;
        int   gap_pct;      // chance of an idle cycle before this request
        bit   drain_first;  // hold off until no result is outstanding
    } stim_t;

    logic clk;
    logic rst_n;
    logic start;
    cha_pkg::req_t request;
    logic busy;
    logic done;
    cha_pkg::res_t result;

    convex_hull_area uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // 12 time unit clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    stim_t pending_q[$];
    cha_pkg::res_t expected_area_q[$];

    int error_count;
    int sets_sent;
    int points_sent;
    int results_checked;
    int gap_pct_now;

    // ------------------------------------------------------------------------
    // graham scan model: own point store, count and drop flag
    // ------------------------------------------------------------------------
    longint set_x[MAX_PTS];
    longint set_y[MAX_PTS];
    int     set_order[MAX_PTS];
    int     set_stack[MAX_PTS];
    int     set_count;
    bit     set_dropped;
    longint pivot_x;
    longint pivot_y;

    // cross product of (b - a) and (c - a), a given by coordinates
    function automatic longint turn_at(longint ax, longint ay, int b, int c);
        return (set_x[b] - ax) * (set_y[c] - ay) - (set_y[b] - ay) * (set_x[c] - ax);
    endfunction

    // strict angular order about the pivot, nearer first on collinear ties
    function automatic bit sorts_ahead(int a, int b);
        longint cp;
        cp = turn_at(pivot_x, pivot_y, a, b);
        if (cp == 0)
            return (set_x[a] + set_y[a]) < (set_x[b] + set_y[b]);
        return cp > 0;
    endfunction

    function automatic logic [cha_pkg::AREA_BITS-1:0] hull_doubled_area();
        int piv;
        int m;
        int k;
        int v;
        int j;
        int top;
        longint sum;
        if (set_count < 3)
            return '0;
        piv = 0;
        for (int i = 1; i < set_count; i++)
            if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
                piv = i;
        pivot_x = set_x[piv];
        pivot_y = set_y[piv];
        m = 0;
        for (int i = 0; i < set_count; i++)
            if (i != piv)
            begin
                set_order[m] = i;
                m++;
            end
        // stable insertion sort
        for (int i = 1; i < m; i++)
        begin
            v = set_order[i];
            j = i;
            while (j > 0 && sorts_ahead(v, set_order[j-1]))
            begin
                set_order[j] = set_order[j-1];
                j--;
            end
            set_order[j] = v;
        end
        set_stack[0] = piv;
        set_stack[1] = set_order[0];
        set_stack[2] = set_order[1];
        k = 3;
        for (int i = 2; i < m; i++)
        begin
            // pop while the turn is not strictly left
            while (k > 1)
            begin
                top = set_stack[k-1];
                k--;
                if (turn_at(set_x[set_stack[k-1]], set_y[set_stack[k-1]], top,
                            set_order[i]) > 0)
                begin
                    k++;
                    break;
                end
            end
            set_stack[k] = set_order[i];
            k++;
        end
        if (k < 3)
            return '0;
        sum = 0;
        for (int i = 1; i + 1 < k; i++)
            sum += turn_at(pivot_x, pivot_y, set_stack[i], set_stack[i+1]);
        if (sum < 0)
            sum = -sum;
        if (sum > longint'(cha_pkg::AREA_MAX))
            return cha_pkg::AREA_MAX;
        return sum[cha_pkg::AREA_BITS-1:0];
    endfunction

    // one accepted point request
    task automatic predict_point(input cha_pkg::req_t r);
        cha_pkg::res_t e;
        if (set_count < MAX_PTS)
        begin
            set_x[set_count] = r.x_coord;
            set_y[set_count] = r.y_coord;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (r.last_point)
        begin
            e.doubled_area = hull_doubled_area();
            e.overflowed = set_dropped;
            expected_area_q.insert(expected_area_q.size(), e);
            set_count = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_point(input int x, input int y, input bit last, input bit drain = 0);
        stim_t s;
        s.req.x_coord = x[15:0];
        s.req.y_coord = y[15:0];
        s.req.last_point = last;
        s.gap_pct = gap_pct_now;
        s.drain_first = drain;
        pending_q.insert(pending_q.size(), s);
        points_sent++;
        if (last)
            sets_sent++;
    endtask

    // random set: full range, a tight cluster (duplicates, collinear runs)
    // or points on one line
    task automatic add_random_set(input int n);
        int flavor;
        int lo;
        int hi;
        int dx;
        int dy;
        int bx;
        int by;
        int t;
        flavor = $urandom_range(0, 3);
        lo = (flavor == 1) ? -4 : -32768;
        hi = (flavor == 1) ? 4 : 32767;
        dx = $urandom_range(0, 6) - 3;
        dy = $urandom_range(0, 6) - 3;
        bx = $urandom_range(0, 200) - 100;
        by = $urandom_range(0, 200) - 100;
        for (int i = 0; i < n; i++)
        begin
            if (flavor == 2)
            begin
                t = $urandom_range(0, 40) - 20;
                add_point(bx + t * dx, by + t * dy, i == n - 1);
            end
            else
                add_point($urandom_range(hi - lo, 0) + lo, $urandom_range(hi - lo, 0) + lo,
                          i == n - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: presents requests at the falling edge, holds until accepted
    // ------------------------------------------------------------------------
    logic taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            taken <= 1'b0;
        else
            taken <= start && !busy;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (taken)
                void'(pending_q.pop_front());
            if (start && !taken)
                start <= 1'b1;  // still waiting for acceptance
            else if (pending_q.size() == 0)
                start <= 1'b0;
            else if (pending_q[0].drain_first && expected_area_q.size() != 0)
                start <= 1'b0;
            else if ($urandom_range(99, 0) < pending_q[0].gap_pct)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                request <= pending_q[0].req;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: model on acceptance, compare on done
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_area_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    if (result.doubled_area !== expected_area_q[0].doubled_area)
                        report_mismatch($sformatf("doubled_area got %0d want %0d",
                            result.doubled_area, expected_area_q[0].doubled_area));
                    if (result.overflowed !== expected_area_q[0].overflowed)
                        report_mismatch($sformatf("overflowed got %0b want %0b",
                            result.overflowed, expected_area_q[0].overflowed));
                    void'(expected_area_q.pop_front());
                    results_checked++;
                end
            end
            // request handed over at this edge
            if (start && !busy)
                predict_point(request);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        error_count = 0;
        sets_sent = 0;
        points_sent = 0;
        results_checked = 0;
        set_count = 0;
        set_dropped = 1'b0;
        gap_pct_now = 0;

        // directed: too few points
        add_point(5, 5, 1);
        add_point(-32768, 32767, 0);
        add_point(32767, -32768, 1);
        // directed: collinear and duplicate sets give no area
        add_point(0, 0, 0);
        add_point(16, 16, 0);
        add_point(-16, -16, 1);
        add_point(7, 7, 0);
        add_point(7, 7, 0);
        add_point(7, 7, 1);
        // directed: full range square, the largest area
        add_point(-32768, -32768, 0);
        add_point(32767, -32768, 0);
        add_point(32767, 32767, 0);
        add_point(-32768, 32767, 1);
        // directed: interior point, pivot tie on y, collinear edge points
        add_point(10, 0, 0);
        add_point(0, 0, 0);
        add_point(5, 0, 0);
        add_point(10, 10, 0);
        add_point(5, 3, 0);
        add_point(0, 10, 0);
        add_point(5, 10, 1);
        // directed: concave shape with duplicates
        add_point(0, 0, 0);
        add_point(20, 0, 0);
        add_point(10, 5, 0);
        add_point(20, 0, 0);
        add_point(10, 30, 1);

        // store full: collinear run in sorted order keeps the sort short,
        // then extra points are dropped, the last one among them
        add_point(0, 0, 0);
        for (int i = 1; i < MAX_PTS - 1; i++)
            add_point(i, 0, 0);
        add_point(0, 100, 0);
        add_point(-500, 900, 0);
        add_point(3000, 3000, 1);

        // random sets in sender phases: none, heavy gaps, light gaps
        while (points_sent < TARGET_POINTS)
        begin
            case ((points_sent / 70) % 3)
                0: gap_pct_now = 0;
                1: gap_pct_now = 77;
                default: gap_pct_now = 18;
            endcase
            if ($urandom_range(0, 40) == 0)
                add_random_set($urandom_range(30, 60));
            else
                add_random_set($urandom_range(1, 12));
            // sender waits for the block to go quiet once
            if (sets_sent == 20)
            begin
                add_point(1, 2, 0, 1);
                add_point(9, 2, 0);
                add_point(4, 8, 1);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && expected_area_q.size() == 0);
        repeat (200) @(posedge clk);

        $display("covered %0d point sets, %0d points, %0d results checked",
                 sets_sent, points_sent, results_checked);
        $display("including degenerate, duplicate, full range and store full sets");
        if (error_count == 0 && expected_area_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hard limit well beyond the slowest correct run
    initial
    begin
        #(12 * 30000000);
        $display("timeout after %0d results", results_checked);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: convex_hull_area.f
hdl/cha_pkg.sv
hdl/cha_ram.sv
hdl/cha_cross.sv
hdl/convex_hull_area.sv
tb/sv/tb_convex_hull_area.sv
